[rtl/ctba_pkg.sv]
// Package with constants, types and adjacency tables for the cube-map tile border address core.
`timescale 1ns / 1ps
package ctba_pkg;

	localparam int MAX_TILE_SIZE_DEF      = 1024;
	localparam int MAX_BORDER_DEF         = 16;
	localparam int MAX_TILES_PER_SIDE_DEF = 16;

	// Configuration register indexes.
	localparam logic [2:0] REG_TILE_WIDTH     = 3'd0;
	localparam logic [2:0] REG_TILE_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_BORDER_WIDTH   = 3'd2;
	localparam logic [2:0] REG_TILES_PER_SIDE = 3'd3;
	localparam logic [2:0] REG_FACE_MASK      = 3'd4;

	// Tile edge codes.
	localparam logic [1:0] EDGE_LEFT   = 2'd0;
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [1:0] EDGE_TOP    = 2'd2;
	localparam logic [1:0] EDGE_BOTTOM = 2'd3;

	// One adjacency entry: neighbor face, its edge, and the two flip bits.
	typedef struct packed {
		logic [2:0] face;
		logic [1:0] edge_id;
		logic       fu;
		logic       fv;
	} adj_t;

	function automatic adj_t adj_lookup(input logic [2:0] face, input logic [1:0] side);
		adj_t r;
		r = '0;
		case ({face, side})
			{3'd0, 2'd0}: r = '{3'd2, 2'd2, 1'b0, 1'b0};
			{3'd0, 2'd1}: r = '{3'd4, 2'd2, 1'b0, 1'b1};
			{3'd0, 2'd2}: r = '{3'd3, 2'd2, 1'b1, 1'b0};
			{3'd0, 2'd3}: r = '{3'd1, 2'd2, 1'b0, 1'b0};
			{3'd1, 2'd0}: r = '{3'd2, 2'd1, 1'b0, 1'b0};
			{3'd1, 2'd1}: r = '{3'd4, 2'd0, 1'b0, 1'b0};
			{3'd1, 2'd2}: r = '{3'd0, 2'd3, 1'b0, 1'b0};
			{3'd1, 2'd3}: r = '{3'd5, 2'd2, 1'b0, 1'b0};
			{3'd2, 2'd0}: r = '{3'd3, 2'd1, 1'b0, 1'b0};
			{3'd2, 2'd1}: r = '{3'd1, 2'd0, 1'b0, 1'b0};
			{3'd2, 2'd2}: r = '{3'd0, 2'd0, 1'b0, 1'b0};
			{3'd2, 2'd3}: r = '{3'd5, 2'd0, 1'b0, 1'b1};
			{3'd3, 2'd0}: r = '{3'd4, 2'd1, 1'b0, 1'b0};
			{3'd3, 2'd1}: r = '{3'd2, 2'd0, 1'b0, 1'b0};
			{3'd3, 2'd2}: r = '{3'd0, 2'd2, 1'b1, 1'b0};
			{3'd3, 2'd3}: r = '{3'd5, 2'd3, 1'b1, 1'b0};
			{3'd4, 2'd0}: r = '{3'd1, 2'd1, 1'b0, 1'b0};
			{3'd4, 2'd1}: r = '{3'd3, 2'd0, 1'b0, 1'b0};
			{3'd4, 2'd2}: r = '{3'd0, 2'd1, 1'b0, 1'b1};
			{3'd4, 2'd3}: r = '{3'd5, 2'd1, 1'b0, 1'b0};
			{3'd5, 2'd0}: r = '{3'd2, 2'd3, 1'b0, 1'b1};
			{3'd5, 2'd1}: r = '{3'd4, 2'd3, 1'b0, 1'b0};
			{3'd5, 2'd2}: r = '{3'd1, 2'd3, 1'b0, 1'b0};
			{3'd5, 2'd3}: r = '{3'd3, 2'd3, 1'b1, 1'b0};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/cubemap_tile_border_address_core.sv]
// Cube-map tile border address core: pipelined source address generator.
//
//   port group   dir   fields (low bit first)
//   s_axis_*     in    tdata: face[2:0], tile_index[10:3], out_x[21:11], out_y[32:22]
//   m_axis_*     out   tdata: src_face[2:0], src_tile[10:3], src_x[20:11], src_y[30:21]
//   cfg_*        in    write enable, register index, 11-bit data
//
// Four register stages; one transfer per clock while the output is not stalled.
// The throughput is set by the stage chain, each stage holding narrow
// adds, compares and small multiplies. Reset (arst_n) clears the valid bits
// and loads the register reset values. On an output stall a stage freezes only
// while it and all later stages hold items; an empty stage still fills, so bubbles close.
`timescale 1ns / 1ps
module cubemap_tile_border_address_core
	import ctba_pkg::*;
#(
	parameter int MAX_TILE_SIZE      = MAX_TILE_SIZE_DEF,
	parameter int MAX_BORDER         = MAX_BORDER_DEF,
	parameter int MAX_TILES_PER_SIDE = MAX_TILES_PER_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// face[2:0], tile_index[10:3], out_x[21:11], out_y[32:22], zero fill
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// src_face[2:0], src_tile[10:3], src_x[20:11], src_y[30:21], zero fill
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	// Signed working width covers coordinates and tile products.
	localparam int SW = 16;

	// Configuration registers.
	logic [10:0] tile_width_q, tile_height_q;
	logic [4:0]  border_width_q, tiles_per_side_q;
	logic [5:0]  face_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q     <= 11'd256;
			tile_height_q    <= 11'd256;
			border_width_q   <= 5'd2;
			tiles_per_side_q <= 5'd4;
			face_mask_q      <= 6'h3f;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILE_WIDTH:     tile_width_q     <= cfg_data;
				REG_TILE_HEIGHT:    tile_height_q    <= cfg_data;
				REG_BORDER_WIDTH:   border_width_q   <= cfg_data[4:0];
				REG_TILES_PER_SIDE: tiles_per_side_q <= cfg_data[4:0];
				REG_FACE_MASK:      face_mask_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Face mask widened so that any 3-bit face code indexes it; codes 6 and 7 read as absent.
	logic [7:0] mask_ext;
	assign mask_ext = {2'b00, face_mask_q};

	// Saturated configuration values.
	logic signed [SW-1:0] w_c, h_c, b_c, n_c;
	always_comb begin
		w_c = (tile_width_q == 11'd0) ? SW'(1) :
			(32'(tile_width_q) > MAX_TILE_SIZE ? SW'(MAX_TILE_SIZE) : SW'(tile_width_q));
		h_c = (tile_height_q == 11'd0) ? SW'(1) :
			(32'(tile_height_q) > MAX_TILE_SIZE ? SW'(MAX_TILE_SIZE) : SW'(tile_height_q));
		b_c = 32'(border_width_q) > MAX_BORDER ? SW'(MAX_BORDER) : SW'(border_width_q);
		n_c = (tiles_per_side_q == 5'd0) ? SW'(1) :
			(32'(tiles_per_side_q) > MAX_TILES_PER_SIDE ? SW'(MAX_TILES_PER_SIDE) :
			SW'(tiles_per_side_q));
	end

	// Pipeline advance: each stage moves when the one after can take it.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: saturate the pixel position, relative coordinates, own-tile check.
	logic [2:0]  face_in;
	logic [7:0]  tile_in;
	logic signed [SW-1:0] ox_in, oy_in, xmax, ymax, ox_c, oy_c;
	assign face_in = s_axis_tdata[2:0];
	assign tile_in = s_axis_tdata[10:3];
	assign ox_in   = SW'(s_axis_tdata[21:11]);
	assign oy_in   = SW'(s_axis_tdata[32:22]);
	assign xmax    = SW'(w_c + 2 * b_c - 1);
	assign ymax    = SW'(h_c + 2 * b_c - 1);
	assign ox_c    = ox_in > xmax ? xmax : ox_in;
	assign oy_c    = oy_in > ymax ? ymax : oy_in;

	logic [2:0]  face_s1;
	logic [7:0]  tile_s1;
	logic signed [SW-1:0] ox_s1, oy_s1, rx_s1, ry_s1;
	logic [1:0]  cx_s1, cy_s1; // bit1 = negative, bit0 = positive
	logic        own_s1;
	logic [4:0]  tx_s1, ty_s1;

	// Tile row and column by stepping over the at most MAX_TILES_PER_SIDE rows (sixteen by default).
	logic [4:0] tx_d, ty_d;
	always_comb begin
		tx_d = '0;
		ty_d = '0;
		for (int r = 0; r < MAX_TILES_PER_SIDE; r++) begin
			if (SW'(tile_in) >= SW'(r) * n_c && SW'(tile_in) < SW'(r + 1) * n_c) begin
				ty_d = 5'(r);
				tx_d = 5'(SW'(tile_in) - SW'(r) * n_c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			face_s1 <= face_in;
			tile_s1 <= tile_in;
			ox_s1   <= ox_c;
			oy_s1   <= oy_c;
			rx_s1   <= ox_c - b_c;
			ry_s1   <= oy_c - b_c;
			cx_s1   <= {ox_c < b_c, ox_c - b_c >= w_c};
			cy_s1   <= {oy_c < b_c, oy_c - b_c >= h_c};
			own_s1  <= face_in < 3'd6 && mask_ext[face_in] && SW'(tile_in) < n_c * n_c;
			tx_s1   <= tx_d;
			ty_s1   <= ty_d;
		end
	end

	// Stage 2: pick the case, look up adjacency and form the flipped tile row or column.
	logic signed [SW-1:0] nx, ny;
	logic in_face, is_side;
	logic [1:0] side;
	adj_t adj;
	always_comb begin
		nx = SW'(tx_s1) + (cx_s1[1] ? -SW'(1) : (cx_s1[0] ? SW'(1) : SW'(0)));
		ny = SW'(ty_s1) + (cy_s1[1] ? -SW'(1) : (cy_s1[0] ? SW'(1) : SW'(0)));
		in_face = nx >= 0 && nx < n_c && ny >= 0 && ny < n_c;
		is_side = (cx_s1 == 2'b00) || (cy_s1 == 2'b00);
		side = cx_s1[1] ? EDGE_LEFT : (cx_s1[0] ? EDGE_RIGHT :
			(cy_s1[1] ? EDGE_TOP : EDGE_BOTTOM));
		adj = adj_lookup(face_s1, side);
	end

	// Modes: own tile clamp, inner neighbor, adjacent face.
	logic [1:0] mode_s2;
	localparam logic [1:0] MODE_OWN = 2'd0, MODE_INNER = 2'd1, MODE_ADJ = 2'd2;
	logic [2:0] face_s2;
	logic [7:0] tile_s2;
	logic signed [SW-1:0] ox_s2, oy_s2, rx_s2, ry_s2, nx_s2, ny_s2, tt_s2;
	logic [1:0] cx_s2, cy_s2, side_s2;
	adj_t adj_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			if (own_s1 && (cx_s1 != 2'b00 || cy_s1 != 2'b00) && in_face)
				mode_s2 <= MODE_INNER;
			else if (own_s1 && (cx_s1 != 2'b00 || cy_s1 != 2'b00) && is_side &&
				mask_ext[adj.face])
				mode_s2 <= MODE_ADJ;
			else
				mode_s2 <= MODE_OWN;
			face_s2 <= face_s1;
			tile_s2 <= tile_s1;
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			rx_s2   <= rx_s1;
			ry_s2   <= ry_s1;
			nx_s2   <= nx;
			ny_s2   <= ny;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			side_s2 <= side;
			adj_s2  <= adj;
			// Flipped tile row or column along the shared edge.
			begin
				logic tflip;
				logic signed [SW-1:0] t;
				tflip = adj.edge_id < 2'd2 ? adj.fv : adj.fu;
				t = side < 2'd2 ? SW'(ty_s1) : SW'(tx_s1);
				tt_s2 <= tflip ? SW'(n_c - 1 - t) : t;
			end
		end
	end

	// Stage 3: source tile products and unclamped source coordinates.
	logic [2:0] sf_s3;
	logic [7:0] st_s3;
	logic signed [SW-1:0] sx_s3, sy_s3;
	logic signed [SW-1:0] d, a, sx_d, sy_d, st_d;
	logic near, pflip;
	always_comb begin
		near  = side_s2 == EDGE_LEFT || side_s2 == EDGE_TOP;
		pflip = (side_s2 < 2'd2 || adj_s2.edge_id < 2'd2) ? adj_s2.fv : adj_s2.fu;
		a     = side_s2 < 2'd2 ? ry_s2 : rx_s2;
		case (side_s2)
			EDGE_LEFT:  d = ox_s2;
			EDGE_RIGHT: d = rx_s2 - w_c;
			EDGE_TOP:   d = oy_s2;
			default:    d = ry_s2 - h_c;
		endcase
		sx_d = rx_s2;
		sy_d = ry_s2;
		st_d = SW'(tile_s2);
		case (mode_s2)
			MODE_INNER: begin
				st_d = ny_s2 * n_c + nx_s2;
				sx_d = rx_s2 - (cx_s2[1] ? -w_c : (cx_s2[0] ? w_c : SW'(0)));
				sy_d = ry_s2 - (cy_s2[1] ? -h_c : (cy_s2[0] ? h_c : SW'(0)));
			end
			MODE_ADJ: begin
				case (adj_s2.edge_id)
					EDGE_LEFT: begin
						st_d = SW'(tt_s2 * n_c + n_c - 1);
						sx_d = near ? SW'(b_c - 1 - d) : d;
						sy_d = pflip ? SW'(h_c - 1 - a) : a;
					end
					EDGE_RIGHT: begin
						st_d = tt_s2 * n_c;
						sx_d = near ? w_c - b_c + d : SW'(w_c - 1 - d);
						sy_d = pflip ? SW'(h_c - 1 - a) : a;
					end
					EDGE_TOP: begin
						st_d = SW'((n_c - 1) * n_c + tt_s2);
						sy_d = near ? SW'(b_c - 1 - d) : d;
						sx_d = pflip ? SW'(w_c - 1 - a) : a;
					end
					default: begin
						st_d = tt_s2;
						sy_d = near ? h_c - b_c + d : SW'(h_c - 1 - d);
						sx_d = pflip ? SW'(w_c - 1 - a) : a;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sf_s3 <= mode_s2 == MODE_ADJ ? adj_s2.face : face_s2;
			st_s3 <= st_d[7:0];
			sx_s3 <= sx_d;
			sy_s3 <= sy_d;
		end
	end

	// Stage 4: clamp into the source tile and register the result.
	logic [2:0] sf_s4;
	logic [7:0] st_s4;
	logic [9:0] sx_s4, sy_s4;
	logic signed [SW-1:0] sxc, syc, wm1, hm1;
	assign wm1 = SW'(w_c - 1);
	assign hm1 = SW'(h_c - 1);
	assign sxc = sx_s3 < 0 ? SW'(0) : (sx_s3 > wm1 ? wm1 : sx_s3);
	assign syc = sy_s3 < 0 ? SW'(0) : (sy_s3 > hm1 ? hm1 : sy_s3);

	always_ff @(posedge clk) begin
		if (en4) begin
			sf_s4 <= sf_s3;
			st_s4 <= st_s3;
			sx_s4 <= sxc[9:0];
			sy_s4 <= syc[9:0];
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {1'b0, sy_s4, sx_s4, st_s4, sf_s4};

	// Checks on pipeline flow.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !m_axis_tready |=> v_s4 && $stable(m_axis_tdata))
		else $error("output item changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input blocked with empty first stage");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item lost");
	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && mode_s2 == MODE_ADJ && en3 |=> sf_s3 < 3'd6)
		else $error("adjacent face out of range");

	logic unused_ok;
	assign unused_ok = ^s_axis_tdata[39:33];

endmodule
